[rtl/cor_pkg.sv]
package cor_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned LenW    = 13;
  localparam int unsigned HeightW = 13;
  localparam int unsigned DecW    = 16;

  localparam int unsigned DefMaxDim   = 4096;
  localparam logic [HeightW-1:0] HeightReset = 13'd4096;

  // Queue between front and back, in jobs
  localparam int unsigned QDepth = 4;

  // Midpoint circle decision constants
  localparam logic [DecW-1:0] DecInit    = 16'd3;
  localparam logic [DecW-1:0] DecIncPlus = 16'd6;
  localparam logic [DecW-1:0] DecIncDiag = 16'd10;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic COLOUR_BLACK = 1'b0;
  localparam logic COLOUR_WHITE = 1'b1;

  typedef enum logic [1:0] {
    JOB_NOWRITE = 2'd0,
    JOB_FILL    = 2'd1,
    JOB_CIRC8   = 2'd2,
    JOB_CIRC4   = 2'd3
  } job_kind_e;

  // One classified step. For circle jobs base_x/base_y hold the centre,
  // off_x/off_y the current Bresenham point and flag the even offset.
  // For fill jobs base_x/base_y hold span start and row, len the width
  // and flag marks the last row.
  typedef struct packed {
    job_kind_e         kind;
    logic [CoordW-1:0] base_x;
    logic [CoordW-1:0] base_y;
    logic [CoordW-1:0] off_x;
    logic [CoordW-1:0] off_y;
    logic [LenW-1:0]   len;
    logic              flag;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[rtl/circle_outline_rasterizer_core.sv]
// Circle outline rasterizer core: midpoint circle in a square, or row fill.
// A step beat passes through the job queue and then the output register.
// Output gives one beat per cycle while out_stall_i is low; a circle step gives 8 beats, the
// diagonal step 4, a fill row or a no-write step 1, a start none.
// Input takes one beat per cycle while the 4-entry job queue has room.
// Reset (rst_ni low, async): idle mode, queue empty, image height 4096.
module circle_outline_rasterizer_core #(
  parameter int unsigned MaxDim = cor_pkg::DefMaxDim
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: image height
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cor_pkg::HeightW-1:0] cfg_image_height_i,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [cor_pkg::CoordW-1:0]  x_left_i,
  input  logic [cor_pkg::CoordW-1:0]  y_low_i,
  input  logic [cor_pkg::CoordW-1:0]  x_right_i,
  input  logic [cor_pkg::CoordW-1:0]  y_high_i,
  // Pixel write channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cor_pkg::CoordW-1:0]  pixel_x_o,
  output logic [cor_pkg::CoordW-1:0]  pixel_y_o,
  output logic [cor_pkg::LenW-1:0]    span_length_o,
  output logic                        colour_o,
  output logic                        write_enable_o,
  output logic                        last_o,
  output logic                        done_res_o
);
  import cor_pkg::*;

  logic      push, pop;
  job_t      job_in, job_head;
  q_status_t q_status;

  // Register writes must come only while idle; the block does not enforce it and takes them at once
  assign cfg_ready_o = 1'b1;

  // Front: latch rectangles, run the Bresenham recurrence, classify each step
  cor_front #(
    .MaxDim(MaxDim)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_image_height_i (cfg_image_height_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .x_left_i           (x_left_i),
    .y_low_i            (y_low_i),
    .x_right_i          (x_right_i),
    .y_high_i           (y_high_i),
    .q_status_i         (q_status),
    .push_o             (push),
    .job_o              (job_in)
  );

  // Short job queue decouples the two sides
  cor_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .head_o   (job_head),
    .status_o (q_status)
  );

  // Back: expand each job into its beats, one per cycle while the output is not stalled
  cor_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (job_head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .span_length_o  (span_length_o),
    .colour_o       (colour_o),
    .write_enable_o (write_enable_o),
    .last_o         (last_o),
    .done_res_o     (done_res_o)
  );

  // A finished shape always closes its step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> last_o)
    else $error("done beat without last");

  // A beat that writes nothing is the closing beat of a finished shape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> last_o && done_res_o && span_length_o == '0)
    else $error("no-write beat malformed");

  // An accepted step leaves work in the queue or on the output the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_STEP |=> !q_status.empty || out_valid_o)
    else $error("accepted step lost");

endmodule

[rtl/cor_front.sv]
module cor_front #(
  parameter int unsigned MaxDim = cor_pkg::DefMaxDim
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [cor_pkg::HeightW-1:0]  cfg_image_height_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [cor_pkg::CoordW-1:0]   x_left_i,
  input  logic [cor_pkg::CoordW-1:0]   y_low_i,
  input  logic [cor_pkg::CoordW-1:0]   x_right_i,
  input  logic [cor_pkg::CoordW-1:0]   y_high_i,
  input  cor_pkg::q_status_t           q_status_i,
  output logic                         push_o,
  output cor_pkg::job_t                job_o
);
  import cor_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CIRCLE,
    MODE_FILL,
    MODE_DONE
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [HeightW-1:0]  height_q;
  logic [CoordW-1:0]   step_x_q, step_x_d;
  logic [CoordW-1:0]   step_y_q, step_y_d;
  logic [DecW-1:0]     dec_q, dec_d;
  logic [CoordW-1:0]   cx_q, cx_d;
  logic [CoordW-1:0]   cy_q, cy_d;
  logic                even_q, even_d;
  logic [CoordW-1:0]   fill_row_q, fill_row_d;
  logic [CoordW-1:0]   fill_end_q, fill_end_d;
  logic [CoordW-1:0]   fill_col_q, fill_col_d;
  logic [LenW-1:0]     fill_w_q, fill_w_d;

  logic                accept;
  logic [HeightW-1:0]  h_eff;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0]   q_side;
  logic [CoordW-2:0]   half;
  logic [CoordW-1:0]   radius;
  logic                x_lt_y;
  logic [DecW-1:0]     xy_diff;
  logic [DecW-1:0]     diff4;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept && (req_type_i == REQ_STEP);

  assign h_eff = (int'(height_q) > int'(MaxDim)) ? HeightW'(MaxDim) : height_q;

  assign dx     = $signed({1'b0, x_right_i}) - $signed({1'b0, x_left_i});
  assign dy     = $signed({1'b0, y_high_i}) - $signed({1'b0, y_low_i});
  assign q_side = dx[CoordW-1:0] - CoordW'(1);
  assign half   = q_side[CoordW-1:1];
  assign radius = {1'b0, half} + CoordW'(q_side[0]);
  assign x_lt_y = step_x_q < step_y_q;
  assign xy_diff = {{(DecW-CoordW){1'b0}}, step_x_q} - {{(DecW-CoordW){1'b0}}, step_y_q};
  assign diff4   = {xy_diff[DecW-3:0], 2'b00};

  always_comb begin
    mode_d     = mode_q;
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    dec_d      = dec_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    even_d     = even_q;
    fill_row_d = fill_row_q;
    fill_end_d = fill_end_q;
    fill_col_d = fill_col_q;
    fill_w_d   = fill_w_q;
    job_o      = '0;
    job_o.kind = JOB_NOWRITE;

    if (accept && req_type_i == REQ_START) begin
      if (dx < 0 || dy < 0 || (dx == 0 && dy == 0)) begin
        mode_d = MODE_DONE;
      end else if (dx == dy) begin
        even_d   = ~q_side[0];
        cx_d     = x_left_i + {1'b0, half} + CoordW'(1);
        cy_d     = h_eff[CoordW-1:0] - (y_low_i + {1'b0, half}) - CoordW'(2);
        step_x_d = '0;
        step_y_d = radius;
        dec_d    = DecInit - {{(DecW-CoordW-1){1'b0}}, radius, 1'b0};
        mode_d   = MODE_CIRCLE;
      end else begin
        fill_col_d = x_left_i;
        fill_w_d   = LenW'(dx[CoordW:0]) + LenW'(1);
        fill_row_d = h_eff[CoordW-1:0] - y_high_i - CoordW'(1);
        fill_end_d = h_eff[CoordW-1:0] - y_low_i - CoordW'(1);
        mode_d     = MODE_FILL;
      end
    end

    // Classify the step against the current mode and advance the state
    unique case (mode_q)
      MODE_FILL: begin
        job_o.kind   = JOB_FILL;
        job_o.base_x = fill_col_q;
        job_o.base_y = fill_row_q;
        job_o.len    = fill_w_q;
        job_o.flag   = (fill_row_q == fill_end_q);
      end
      MODE_CIRCLE: begin
        job_o.kind   = x_lt_y ? JOB_CIRC8 :
                       (step_x_q == step_y_q) ? JOB_CIRC4 : JOB_NOWRITE;
        job_o.base_x = cx_q;
        job_o.base_y = cy_q;
        job_o.off_x  = step_x_q;
        job_o.off_y  = step_y_q;
        job_o.len    = LenW'(1);
        job_o.flag   = even_q;
      end
      MODE_IDLE, MODE_DONE: begin
        job_o.kind = JOB_NOWRITE;
      end
      default: job_o.kind = JOB_NOWRITE;
    endcase

    if (push_o) begin
      unique case (mode_q)
        MODE_FILL: begin
          if (fill_row_q == fill_end_q) begin
            mode_d = MODE_DONE;
          end else begin
            fill_row_d = fill_row_q + CoordW'(1);
          end
        end
        MODE_CIRCLE: begin
          if (x_lt_y) begin
            if (dec_q[DecW-1]) begin
              dec_d = dec_q + {{(DecW-CoordW-2){1'b0}}, step_x_q, 2'b00} + DecIncPlus;
            end else begin
              dec_d    = dec_q + diff4 + DecIncDiag;
              step_y_d = step_y_q - CoordW'(1);
            end
            step_x_d = step_x_q + CoordW'(1);
          end else begin
            mode_d = MODE_DONE;
          end
        end
        MODE_IDLE, MODE_DONE: begin
          mode_d = mode_q;
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      height_q   <= HeightReset;
      step_x_q   <= '0;
      step_y_q   <= '0;
      dec_q      <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      even_q     <= 1'b0;
      fill_row_q <= '0;
      fill_end_q <= '0;
      fill_col_q <= '0;
      fill_w_q   <= '0;
    end else begin
      mode_q     <= mode_d;
      step_x_q   <= step_x_d;
      step_y_q   <= step_y_d;
      dec_q      <= dec_d;
      cx_q       <= cx_d;
      cy_q       <= cy_d;
      even_q     <= even_d;
      fill_row_q <= fill_row_d;
      fill_end_q <= fill_end_d;
      fill_col_q <= fill_col_d;
      fill_w_q   <= fill_w_d;
      if (cfg_valid_i) begin
        height_q <= cfg_image_height_i;
      end
    end
  end

endmodule

[rtl/cor_queue.sv]
module cor_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cor_pkg::job_t      job_i,
  input  logic               pop_i,
  output cor_pkg::job_t      head_o,
  output cor_pkg::q_status_t status_o
);
  import cor_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(QDepth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

[rtl/cor_back.sv]
module cor_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cor_pkg::job_t               head_i,
  input  cor_pkg::q_status_t          q_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cor_pkg::CoordW-1:0]  pixel_x_o,
  output logic [cor_pkg::CoordW-1:0]  pixel_y_o,
  output logic [cor_pkg::LenW-1:0]    span_length_o,
  output logic                        colour_o,
  output logic                        write_enable_o,
  output logic                        last_o,
  output logic                        done_res_o
);
  import cor_pkg::*;

  logic [2:0]        idx_q;
  logic              out_valid_q;
  logic [CoordW-1:0] px_q, py_q;
  logic [LenW-1:0]   len_q;
  logic              colour_q, we_q, last_q, done_q;

  logic              advance, emit;
  logic [CoordW-1:0] u, v, a, px, py;
  logic [LenW-1:0]   len;
  logic              colour, we, last, done;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && !q_status_i.empty;
  assign pop_o   = emit && last;

  // Octant point: bit 2 swaps x and y, bit 1 mirrors the column,
  // bit 0 mirrors the row
  assign u  = idx_q[2] ? head_i.off_y : head_i.off_x;
  assign v  = idx_q[2] ? head_i.off_x : head_i.off_y;
  assign a  = CoordW'(head_i.flag);

  always_comb begin
    px     = '0;
    py     = '0;
    len    = '0;
    colour = COLOUR_BLACK;
    we     = 1'b0;
    last   = 1'b1;
    done   = 1'b1;
    unique case (head_i.kind)
      JOB_FILL: begin
        px   = head_i.base_x;
        py   = head_i.base_y;
        len  = head_i.len;
        we   = 1'b1;
        done = head_i.flag;
      end
      JOB_CIRC8, JOB_CIRC4: begin
        px     = idx_q[1] ? head_i.base_x - u - a : head_i.base_x + u;
        py     = idx_q[0] ? head_i.base_y - v : head_i.base_y + v + a;
        len    = head_i.len;
        colour = COLOUR_WHITE;
        we     = 1'b1;
        if (head_i.kind == JOB_CIRC8) begin
          last = (idx_q == 3'd7);
          done = 1'b0;
        end else begin
          last = (idx_q == 3'd3);
          done = last;
        end
      end
      JOB_NOWRITE: begin
        last = 1'b1;
      end
      default: last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      len_q       <= '0;
      colour_q    <= 1'b0;
      we_q        <= 1'b0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
      if (emit) begin
        px_q     <= px;
        py_q     <= py;
        len_q    <= len;
        colour_q <= colour;
        we_q     <= we;
        last_q   <= last;
        done_q   <= done;
        idx_q    <= last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign span_length_o  = len_q;
  assign colour_o       = colour_q;
  assign write_enable_o = we_q;
  assign last_o         = last_q;
  assign done_res_o     = done_q;

endmodule
